### hw/rtl/timestamped_history_interpolator_core_assert.svh
// Assertion macros shared by the checker files of this block.
// The first macro checks a condition in the same cycle, and the second
// checks it in the cycle after.
`ifndef TIMESTAMPED_HISTORY_INTERPOLATOR_CORE_ASSERT_SVH
`define TIMESTAMPED_HISTORY_INTERPOLATOR_CORE_ASSERT_SVH

// Checks that CON holds in the cycle where ANT holds.
`define THI_ASSERT_SAME(NAME, CLK, RST, ANT, CON, MSG) \
   NAME: assert property (@(posedge CLK) disable iff (RST) (ANT) |-> (CON)) else $error(MSG);

// Checks that CON holds in the cycle after ANT holds.
`define THI_ASSERT_NEXT(NAME, CLK, RST, ANT, CON, MSG) \
   NAME: assert property (@(posedge CLK) disable iff (RST) (ANT) |=> (CON)) else $error(MSG);

`endif

### hw/rtl/thi_pkg.sv
// -----------------------------------------------------------------------------
// thi_pkg
// Shared types and constants for the timestamped history interpolator.
// -----------------------------------------------------------------------------
`default_nettype none
package thi_pkg;

   // Default ring depth.
   localparam int THI_DEPTH = 16;

   // Field widths fixed by the interface.
   localparam int STAMP_W = 32;
   localparam int VAL_W   = 32;
   localparam int NFIELD  = 5;
   localparam int CAP_W   = 5;
   localparam int OP_W    = 2;
   localparam int RATIO_W = 17;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Reset value of the capacity register.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Order of the value fields in a stored sample.
   localparam int F_YAW     = 0;
   localparam int F_PITCH   = 1;
   localparam int F_ROLL    = 2;
   localparam int F_SPEED_X = 3;
   localparam int F_SPEED_Y = 4;

   typedef logic [NFIELD-1:0][VAL_W-1:0] vals_type;

   // One stored sample.
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      vals_type           val;
   } entry_type;

   // Divider start request.
   typedef struct packed {
      logic               start;
      logic [STAMP_W-1:0] num;
      logic [STAMP_W-1:0] den;
   } div_req_type;

   // Divider completion.
   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] ratio;
   } div_rsp_type;

endpackage
`default_nettype wire

### hw/rtl/thi_req_if.sv
// -----------------------------------------------------------------------------
// thi_req_if
// Request channel: operation, time stamp and sample values.
// -----------------------------------------------------------------------------
`default_nettype none
interface thi_req_if;
   import thi_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [STAMP_W-1:0]  stamp;
   logic signed [VAL_W-1:0] yaw_in;
   logic signed [VAL_W-1:0] pitch_in;
   logic signed [VAL_W-1:0] roll_in;
   logic signed [VAL_W-1:0] speed_x_in;
   logic signed [VAL_W-1:0] speed_y_in;

   modport source (output valid, op, stamp, yaw_in, pitch_in, roll_in, speed_x_in,
                   speed_y_in, input ready);
   modport sink (input valid, op, stamp, yaw_in, pitch_in, roll_in, speed_x_in,
                 speed_y_in, output ready);
endinterface
`default_nettype wire

### hw/rtl/thi_rsp_if.sv
// -----------------------------------------------------------------------------
// thi_rsp_if
// Response channel: returned sample and the number of samples held.
// -----------------------------------------------------------------------------
`default_nettype none
interface thi_rsp_if #(parameter int CNT_W = 5);
   import thi_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [STAMP_W-1:0]  stamp_out;
   logic signed [VAL_W-1:0] yaw_out;
   logic signed [VAL_W-1:0] pitch_out;
   logic signed [VAL_W-1:0] roll_out;
   logic signed [VAL_W-1:0] speed_x_out;
   logic signed [VAL_W-1:0] speed_y_out;
   logic [CNT_W-1:0]    held_count;

   modport source (output valid, found, stamp_out, yaw_out, pitch_out, roll_out,
                   speed_x_out, speed_y_out, held_count, input ready);
   modport sink (input valid, found, stamp_out, yaw_out, pitch_out, roll_out,
                 speed_x_out, speed_y_out, held_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/timestamped_history_interpolator_core.sv
// -----------------------------------------------------------------------------
// timestamped_history_interpolator_core
// Ring of timestamped pose samples with linear interpolation on query.
// -----------------------------------------------------------------------------
//  Channel  Direction  Handshake      Contents
//  req      in         valid/ready    op, stamp, five sample values
//  rsp      out        valid/ready    found, stamp, five values, held count
//  csr      in         write enable   capacity
//
//  Push, clear and unknown operations, and a query on an empty ring, go from
//  acceptance to the DONE state and then into the response register. Other
//  queries read the oldest and then the newest entry, walk the stored pairs
//  through the single memory read port if needed, and when they interpolate
//  use the divider and then the shared multiplier for each value field.
//  Synchronous reset empties the ring at once; the sample memory is not cleared.
//  A new transaction is taken once the previous one has moved to the output
//  register, so a stalled response blocks only the following transaction.
// -----------------------------------------------------------------------------
`default_nettype none
module timestamped_history_interpolator_core #(
   parameter int DEPTH = thi_pkg::THI_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   thi_req_if.sink                         req,
   thi_rsp_if.source                       rsp,
   input  wire logic                       csr_we,
   input  wire logic [thi_pkg::CAP_W-1:0]  csr_wdata
);
   import thi_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int SUM_W = CNT_W + 1;
   localparam int PROD_W = VAL_W + 1 + RATIO_W + 1;

   // State codes.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FIRST = 4'd1;
   localparam logic [3:0] ST_LAST  = 4'd2;
   localparam logic [3:0] ST_RD    = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_ADD   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   // Position in the ring to memory slot, wrapping at DEPTH.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(pos);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Sample memory: one write port, one registered read port.
   entry_type          mem [DEPTH];
   entry_type          mem_q;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic [3:0]         state_ff, state_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [STAMP_W-1:0] target_ff, target_in;
   entry_type          prev_ff, prev_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [2:0]         fld_ff, fld_in;
   logic [VAL_W-1:0]   prod_ff, prod_in;
   logic               res_found_ff, res_found_in;
   logic [STAMP_W-1:0] res_stamp_ff, res_stamp_in;
   vals_type           res_val_ff, res_val_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [STAMP_W-1:0] rsp_stamp_ff;
   vals_type           rsp_val_ff;
   logic [CNT_W-1:0]   rsp_count_ff;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               req_fire;
   logic               rsp_load;
   logic [CMP_W-1:0]   eff_cap;
   logic [CNT_W-1:0]   cnt_grow;
   logic [IDX_W-1:0]   old_grow;
   logic [STAMP_W-1:0] pair_dt;
   logic signed [VAL_W:0]   diff_val;
   logic signed [PROD_W-1:0] prod_full;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   // Capacity clamped to 1..DEPTH.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   // Push: count and oldest slot after the append, before the capacity trim.
   always_comb begin
      if (count_ff < CNT_W'(DEPTH)) begin
         cnt_grow = count_ff + CNT_W'(1);
         old_grow = oldest_ff;
      end else begin
         cnt_grow = count_ff;
         old_grow = slot_of(oldest_ff, CNT_W'(1));
      end
   end

   // Shared multiplier for the five value fields.
   assign pair_dt   = mem_q.stamp - prev_ff.stamp;
   assign diff_val  = $signed({mem_q.val[fld_ff][VAL_W-1], mem_q.val[fld_ff]})
                    - $signed({prev_ff.val[fld_ff][VAL_W-1], prev_ff.val[fld_ff]});
   assign prod_full = diff_val * $signed({1'b0, ratio_ff});

   // Sequencer: push and clear update the ring at acceptance; a query reads
   // the oldest and newest entries, then walks adjacent pairs. Each operation
   // finishes before the next is taken, so reads never overlap a write.
   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      target_in    = target_ff;
      prev_in      = prev_ff;
      ratio_in     = ratio_ff;
      fld_in       = fld_ff;
      prod_in      = prod_ff;
      res_found_in = res_found_ff;
      res_stamp_in = res_stamp_ff;
      res_val_in   = res_val_ff;
      rd_en        = 1'b0;
      rd_addr      = oldest_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(oldest_ff, count_ff);
      wr_data.stamp = req.stamp;
      wr_data.val[F_YAW]     = req.yaw_in;
      wr_data.val[F_PITCH]   = req.pitch_in;
      wr_data.val[F_ROLL]    = req.roll_in;
      wr_data.val[F_SPEED_X] = req.speed_x_in;
      wr_data.val[F_SPEED_Y] = req.speed_y_in;
      div_req.start = 1'b0;
      div_req.num   = target_ff - prev_ff.stamp;
      div_req.den   = pair_dt;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_found_in = 1'b0;
               res_stamp_in = '0;
               res_val_in   = '0;
               target_in    = req.stamp;
               state_in     = ST_DONE;
               if (req.op == OP_PUSH) begin
                  wr_en = 1'b1;
                  if (CMP_W'(cnt_grow) > eff_cap) begin
                     oldest_in = slot_of(old_grow, CNT_W'(1));
                     count_in  = cnt_grow - CNT_W'(1);
                  end else begin
                     oldest_in = old_grow;
                     count_in  = cnt_grow;
                  end
               end else if (req.op == OP_CLEAR) begin
                  oldest_in = '0;
                  count_in  = '0;
               end else if (req.op == OP_QUERY && count_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = oldest_ff;
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            prev_in = mem_q;
            if (target_ff <= mem_q.stamp) begin
               res_found_in = 1'b1;
               res_stamp_in = mem_q.stamp;
               res_val_in   = mem_q.val;
               state_in     = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = slot_of(oldest_ff, count_ff - CNT_W'(1));
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (target_ff >= mem_q.stamp) begin
               res_found_in = 1'b1;
               res_stamp_in = mem_q.stamp;
               res_val_in   = mem_q.val;
               state_in     = ST_DONE;
            end else begin
               pos_in   = CNT_W'(1);
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(oldest_ff, pos_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (target_ff >= prev_ff.stamp && target_ff <= mem_q.stamp) begin
               res_found_in = 1'b1;
               if (pair_dt == '0) begin
                  res_stamp_in = prev_ff.stamp;
                  res_val_in   = prev_ff.val;
                  state_in     = ST_DONE;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end else begin
               prev_in = mem_q;
               if (pos_ff == count_ff - CNT_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  pos_in   = pos_ff + CNT_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.ratio;
               fld_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = prod_full[VAL_W+15:16];
            state_in = ST_ADD;
         end
         ST_ADD: begin
            res_val_in[fld_ff] = prev_ff.val[fld_ff] + prod_ff;
            if (fld_ff == 3'(NFIELD - 1)) begin
               res_stamp_in = target_ff;
               state_in     = ST_DONE;
            end else begin
               fld_in   = fld_ff + 3'd1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Sample memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
      pos_ff       <= pos_in;
      target_ff    <= target_in;
      prev_ff      <= prev_in;
      ratio_ff     <= ratio_in;
      fld_ff       <= fld_in;
      prod_ff      <= prod_in;
      res_found_ff <= res_found_in;
      res_stamp_ff <= res_stamp_in;
      res_val_ff   <= res_val_in;
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_stamp_ff <= res_stamp_ff;
         rsp_val_ff   <= res_val_ff;
         rsp_count_ff <= count_ff;
      end
   end

   thi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.stamp_out   = rsp_stamp_ff;
   assign rsp.yaw_out     = rsp_val_ff[F_YAW];
   assign rsp.pitch_out   = rsp_val_ff[F_PITCH];
   assign rsp.roll_out    = rsp_val_ff[F_ROLL];
   assign rsp.speed_x_out = rsp_val_ff[F_SPEED_X];
   assign rsp.speed_y_out = rsp_val_ff[F_SPEED_Y];
   assign rsp.held_count  = rsp_count_ff;

endmodule
`default_nettype wire

### hw/rtl/thi_div.sv
// -----------------------------------------------------------------------------
// thi_div
// Restoring divider for the interpolation ratio floor(num * 65536 / den),
// valid for num <= den and den != 0. One quotient bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module thi_div (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire thi_pkg::div_req_type div_req,
   output thi_pkg::div_rsp_type div_rsp
);
   import thi_pkg::*;

   localparam int REM_W  = STAMP_W + 1;
   localparam int STEP_W = $clog2(RATIO_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;
   logic [STAMP_W-1:0] den_ff, den_in;
   logic [REM_W-1:0]   rem_dbl;

   // The top quotient bit is set when num is at least den (num equals den for valid
   // inputs); the rest come from shifting the remainder one bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_dbl = {rem_ff[REM_W-2:0], 1'b0};
      if (div_req.start) begin
         busy_in = 1'b1;
         den_in  = div_req.den;
         step_in = STEP_W'(RATIO_W - 1);
         if (div_req.num >= div_req.den) begin
            rem_in = {1'b0, div_req.num - div_req.den};
            quo_in = RATIO_W'(1);
         end else begin
            rem_in = {1'b0, div_req.num};
            quo_in = '0;
         end
      end else if (busy_ff) begin
         if (rem_dbl >= {1'b0, den_ff}) begin
            rem_in = rem_dbl - {1'b0, den_ff};
            quo_in = {quo_ff[RATIO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_dbl;
            quo_in = {quo_ff[RATIO_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.ratio = quo_ff;

endmodule
`default_nettype wire

### hw/rtl/thi_checker.sv
// -----------------------------------------------------------------------------
// thi_checker
// Port-level checks on the response channel of the interpolator core.
// -----------------------------------------------------------------------------
`default_nettype none
`include "timestamped_history_interpolator_core_assert.svh"
module thi_checker #(
   parameter int DEPTH = thi_pkg::THI_DEPTH
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_found,
   input wire logic [thi_pkg::STAMP_W-1:0]   rsp_stamp_out,
   input wire logic [thi_pkg::VAL_W-1:0]     rsp_yaw_out,
   input wire logic [$clog2(DEPTH+1)-1:0]    rsp_held_count
);
   import thi_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // A stalled transaction keeps its valid flag, stamp and held count.
   `THI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_stamp_out) && $stable(rsp_held_count), "response changed while stalled")

   // The ring never reports more samples than it can hold.
   `THI_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, rsp_held_count <= CNT_W'(DEPTH), "held count above depth")

   // A response without a state carries a zero stamp and a zero yaw value.
   `THI_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid && !rsp_found, rsp_stamp_out == '0 && rsp_yaw_out == '0, "nonzero fields without a state")

   // A state can only come from a non-empty ring.
   `THI_ASSERT_SAME(a_found_nonempty, clock, reset, rsp_valid && rsp_found, rsp_held_count != '0, "state returned from an empty ring")

endmodule

bind timestamped_history_interpolator_core thi_checker #(.DEPTH(DEPTH)) u_thi_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_found      (rsp.found),
   .rsp_stamp_out  (rsp.stamp_out),
   .rsp_yaw_out    (rsp.yaw_out),
   .rsp_held_count (rsp.held_count)
);
`default_nettype wire

### tb/sv/thi_tb_pkg.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// thi_tb_pkg
// Transaction types and the unknown operation code used by the interpolator bench.
// -----------------------------------------------------------------------------
package thi_tb_pkg;
   import thi_pkg::*;

   // Operation code that the block ignores.
   localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

   // One request transaction.
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [STAMP_W-1:0] stamp;
      vals_type           val;
   } req_item_type;

   // One response transaction.
   typedef struct packed {
      logic               found;
      logic [STAMP_W-1:0] stamp;
      vals_type           val;
      logic [4:0]         count;
   } pose_type;

endpackage

### tb/sv/timestamped_history_interpolator_core_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// timestamped_history_interpolator_core_tb
// Self-checking bench for the pose history ring: random and directed pushes,
// queries and clears are predicted in the bench and compared per response.
// -----------------------------------------------------------------------------
module timestamped_history_interpolator_core_tb;
   import thi_pkg::*;
   import thi_tb_pkg::*;

   localparam int MAX_QUERY = 2 * THI_DEPTH + 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   thi_req_if req ();
   thi_rsp_if rsp ();

   timestamped_history_interpolator_core u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Predicted history state.
   logic [STAMP_W-1:0] hist_stamp [THI_DEPTH];
   vals_type           hist_val [THI_DEPTH];
   int unsigned        hist_oldest = 0;
   int unsigned        hist_count = 0;
   int unsigned        hist_cap = 16;

   req_item_type pending_reqs [$];
   pose_type     expected_poses [$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        recv_hold = 0;
   int        errors = 0;
   int        n_found = 0;
   int        n_blend = 0;
   int        n_checked = 0;

   function automatic int unsigned slot_at(int unsigned pos);
      return (hist_oldest + pos) % THI_DEPTH;
   endfunction

   // Linear blend with the step rounded toward minus infinity.
   function automatic logic [VAL_W-1:0] blend_val(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                                  longint ratio);
      longint va, prod, step;
      va = longint'($signed(a));
      prod = (longint'($signed(b)) - va) * ratio;
      step = prod >>> 16;
      return VAL_W'(va + step);
   endfunction

   // Applies one transaction to the predicted history and returns the response.
   function automatic pose_type predict_pose(req_item_type it);
      pose_type r;
      int unsigned s, sa, sb, eff;
      logic [STAMP_W-1:0] s1, s2;
      longint ratio;
      r = '0;
      eff = (hist_cap < 1) ? 1 : (hist_cap > THI_DEPTH ? THI_DEPTH : hist_cap);
      if (it.op == OP_PUSH) begin
         s = slot_at(hist_count);
         hist_stamp[s] = it.stamp;
         hist_val[s] = it.val;
         if (hist_count < THI_DEPTH) hist_count++;
         else hist_oldest = slot_at(1);
         if (hist_count > eff) begin
            hist_oldest = slot_at(1);
            hist_count--;
         end
      end else if (it.op == OP_QUERY && hist_count != 0) begin
         sa = slot_at(0);
         sb = slot_at(hist_count - 1);
         if (it.stamp <= hist_stamp[sa]) begin
            r.found = 1'b1; r.stamp = hist_stamp[sa]; r.val = hist_val[sa];
         end else if (it.stamp >= hist_stamp[sb]) begin
            r.found = 1'b1; r.stamp = hist_stamp[sb]; r.val = hist_val[sb];
         end else begin
            for (int i = 0; i + 1 < hist_count; i++) begin
               sa = slot_at(i);
               sb = slot_at(i + 1);
               s1 = hist_stamp[sa];
               s2 = hist_stamp[sb];
               if (it.stamp >= s1 && it.stamp <= s2) begin
                  r.found = 1'b1;
                  if (s2 == s1) begin
                     r.stamp = s1; r.val = hist_val[sa];
                  end else begin
                     ratio = longint'({32'd0, it.stamp - s1} << 16) / longint'(s2 - s1);
                     r.stamp = it.stamp;
                     for (int f = 0; f < NFIELD; f++)
                        r.val[f] = blend_val(hist_val[sa][f], hist_val[sb][f], ratio);
                  end
                  break;
               end
            end
         end
      end else if (it.op == OP_CLEAR) begin
         hist_oldest = 0;
         hist_count = 0;
      end
      r.count = 5'(hist_count);
      return r;
   endfunction

   // Driver: offers queued transactions; the offered one stays at the queue head
   // until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            pending_reqs.delete(0);
         end
         if ((req.valid && !req.ready) ||
             (pending_reqs.size() != 0 &&
              $urandom_range(99) >= send_idle_pct)) begin
            if (!(req.valid && !req.ready)) begin
               req.op <= pending_reqs[0].op;
               req.stamp <= pending_reqs[0].stamp;
               req.yaw_in <= pending_reqs[0].val[F_YAW];
               req.pitch_in <= pending_reqs[0].val[F_PITCH];
               req.roll_in <= pending_reqs[0].val[F_ROLL];
               req.speed_x_in <= pending_reqs[0].val[F_SPEED_X];
               req.speed_y_in <= pending_reqs[0].val[F_SPEED_Y];
            end
            req.valid <= 1'b1;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Prediction at acceptance, on the values the block actually took.
   always @(posedge clock) begin
      req_item_type it;
      if (!reset && req.valid && req.ready) begin
         it.op = req.op;
         it.stamp = req.stamp;
         it.val[F_YAW] = req.yaw_in;
         it.val[F_PITCH] = req.pitch_in;
         it.val[F_ROLL] = req.roll_in;
         it.val[F_SPEED_X] = req.speed_x_in;
         it.val[F_SPEED_Y] = req.speed_y_in;
         expected_poses.insert(expected_poses.size(), predict_pose(it));
      end
   end

   // Long receiver hold-off, counted down one cycle at a time.
   always @(posedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
      end
   end

   // Monitor: compares each response transaction with the oldest prediction.
   always @(posedge clock) begin
      pose_type exp_p;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_poses.size() == 0) begin
               $error("response with no transaction outstanding");
               errors++;
            end else begin
               exp_p = expected_poses[0];
               expected_poses.delete(0);
               n_checked++;
               if (exp_p.found) n_found++;
               if (exp_p.found !== rsp.found) begin
                  $error("found: expected %0d, got %0d", exp_p.found, rsp.found); errors++;
               end
               if (exp_p.stamp !== rsp.stamp_out) begin
                  $error("stamp_out: expected %h, got %h", exp_p.stamp, rsp.stamp_out);
                  errors++;
               end
               if (exp_p.val[F_YAW] !== rsp.yaw_out) begin
                  $error("yaw_out: expected %h, got %h", exp_p.val[F_YAW], rsp.yaw_out);
                  errors++;
               end
               if (exp_p.val[F_PITCH] !== rsp.pitch_out) begin
                  $error("pitch_out: expected %h, got %h", exp_p.val[F_PITCH], rsp.pitch_out);
                  errors++;
               end
               if (exp_p.val[F_ROLL] !== rsp.roll_out) begin
                  $error("roll_out: expected %h, got %h", exp_p.val[F_ROLL], rsp.roll_out);
                  errors++;
               end
               if (exp_p.val[F_SPEED_X] !== rsp.speed_x_out) begin
                  $error("speed_x_out: expected %h, got %h", exp_p.val[F_SPEED_X],
                         rsp.speed_x_out);
                  errors++;
               end
               if (exp_p.val[F_SPEED_Y] !== rsp.speed_y_out) begin
                  $error("speed_y_out: expected %h, got %h", exp_p.val[F_SPEED_Y],
                         rsp.speed_y_out);
                  errors++;
               end
               if (exp_p.count !== rsp.held_count) begin
                  $error("held_count: expected %0d, got %0d", exp_p.count, rsp.held_count);
                  errors++;
               end
            end
         end
         if (recv_hold > 0) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Queues one transaction for the driver.
   task automatic queue_req(logic [OP_W-1:0] op, logic [STAMP_W-1:0] stamp, vals_type v);
      req_item_type it;
      it.op = op;
      it.stamp = stamp;
      it.val = v;
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   function automatic vals_type rand_vals();
      vals_type v;
      for (int f = 0; f < NFIELD; f++) v[f] = $urandom();
      return v;
   endfunction

   // Waits until every queued transaction has been answered, then lets the block settle.
   task automatic drain();
      while (pending_reqs.size() != 0 || req.valid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (MAX_QUERY) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      hist_cap = cap;
   endtask

   // Mostly ordered stamp histories with most queries at or below the newest stamp.
   task automatic queue_random(int n);
      logic [STAMP_W-1:0] base;
      int unsigned k;
      base = $urandom();
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 45) begin
            base = base + ((k < 3) ? $urandom() : $urandom_range(2000));
            queue_req(OP_PUSH, base, rand_vals());
         end else if (k < 88) begin
            queue_req(OP_QUERY, base - $urandom_range(30000), rand_vals());
         end else if (k < 93) begin
            queue_req(OP_QUERY, $urandom(), rand_vals());
         end else if (k < 96) begin
            queue_req(OP_CLEAR, $urandom(), rand_vals());
         end else begin
            queue_req(OP_UNKNOWN, $urandom(), rand_vals());
         end
      end
   endtask

   initial begin
      vals_type vmax, vmin;
      int unsigned caps [6] = '{16, 0, 1, 31, 3, 16};
      req.valid = 1'b0;
      req.op = '0; req.stamp = '0;
      req.yaw_in = '0; req.pitch_in = '0; req.roll_in = '0;
      req.speed_x_in = '0; req.speed_y_in = '0;
      rsp.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty query, extremes, duplicates, out-of-order stamps, odd ops.
      for (int f = 0; f < NFIELD; f++) begin
         vmax[f] = 32'h7fff_ffff;
         vmin[f] = 32'h8000_0000;
      end
      queue_req(OP_QUERY, 32'd5, '0);
      queue_req(OP_PUSH, 32'd0, vmin);
      queue_req(OP_PUSH, 32'hffff_ffff, vmax);
      queue_req(OP_QUERY, 32'h8000_0000, '0);
      queue_req(OP_QUERY, 32'd1, '0);
      queue_req(OP_QUERY, 32'hffff_fffe, '0);
      queue_req(OP_QUERY, 32'd0, '0);
      queue_req(OP_QUERY, 32'hffff_ffff, '0);
      queue_req(OP_PUSH, 32'hffff_ffff, vmin);
      queue_req(OP_QUERY, 32'hffff_fffe, '0);
      queue_req(OP_UNKNOWN, 32'hffff_ffff, vmax);
      queue_req(OP_CLEAR, '0, '0);
      queue_req(OP_PUSH, 32'd100, vmax);
      queue_req(OP_PUSH, 32'd50, vmin);
      queue_req(OP_PUSH, 32'd200, vmin);
      queue_req(OP_QUERY, 32'd120, '0);
      queue_req(OP_QUERY, 32'd70, '0);
      queue_req(OP_QUERY, 32'd150, '0);
      queue_req(OP_CLEAR, '0, '0);
      drain();

      // Random phases across capacity settings and idle patterns.
      for (int p = 0; p < 6; p++) begin
         write_capacity(CAP_W'(caps[p]));
         send_idle_pct = (p < 2) ? 27 : (p < 4 ? 73 : 0);
         recv_idle_pct = (p < 2) ? 73 : (p < 4 ? 27 : 0);
         if (p == 2) recv_hold = 300;
         queue_random(290);
         drain();
      end

      $display("Checked %0d responses, %0d with a returned state, over six capacity settings.",
               n_checked, n_found);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #40ms;
      $display("FAILURE");
      $finish;
   end

endmodule
